// ----- hw/rtl/mhpq_pkg.sv -----
// Shared types and constants for the min-heap priority queue.
// No dependencies; min_heap_priority_queue imports this package, mhpq_ram does not.
`default_nettype none

package mhpq_pkg;

  // Heap geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int KEY_W    = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [KEY_W-1:0]  key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key_out;
    status_t                  status;
    logic [CNT_W-1:0]         count_after;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mhpq_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No package dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  output logic      [WIDTH-1:0]         rdata0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and both registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/min_heap_priority_queue.sv -----
// Top level of the min-heap priority queue: control sequencer around the heap RAM.
// Depends on mhpq_pkg and mhpq_ram.
//
//   channel | ports                        | carries
//   --------+------------------------------+-------------------------------
//   input   | in_valid / in_ready / in_data     | opcode, key_in
//   result  | out_valid / out_ready / out_data  | key_out, status, count_after
//
// One item is in flight at a time; in_ready is high only while the sequencer is idle.
// Insert: into an empty heap the key is written straight to the root, else it rises level by level.
// Remove: the root and last entry are fetched together; unless the heap is then empty, the last entry sinks.
// Refused items go straight to the result stage.
// The single RAM write port limits the sift to one heap level per cycle.
// Reset (synchronous, rst_n low) empties the heap; RAM contents are not cleared.
// A finished result waits in the sequencer while the output register is still held.
`default_nettype none

module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_UP,
    S_DOWN,
    S_PLACE,
    S_DONE
  } state_t;

  state_t                  state_r,     state_nxt;
  logic [CNT_W-1:0]        count_r,     count_nxt;
  logic [IDX_W-1:0]        pos_r,       pos_nxt;
  logic signed [KEY_W-1:0] key_r,       key_nxt;
  logic signed [KEY_W-1:0] res_key_r,   res_key_nxt;
  status_t                 res_stat_r,  res_stat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r,  out_data_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [KEY_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr0;
  logic [IDX_W-1:0]        ram_raddr1;
  logic [KEY_W-1:0]        ram_rdata0;
  logic [KEY_W-1:0]        ram_rdata1;

  logic                    in_xfer;
  logic [IDX_W-1:0]        par_idx;
  logic [IDX_W+1:0]        left_idx;
  logic [IDX_W+1:0]        right_idx;
  logic                    left_ok;
  logic                    right_ok;
  logic                    take_left;
  logic                    take_right;
  logic signed [KEY_W-1:0] left_key;
  logic signed [KEY_W-1:0] right_key;
  logic signed [KEY_W-1:0] best_key;

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] pm1;
    pm1 = p - 1'b1;
    return pm1 >> 1;
  endfunction

  function automatic logic [IDX_W+1:0] left_of(input logic [IDX_W-1:0] p);
    return {1'b0, p, 1'b1};
  endfunction

  function automatic logic [IDX_W+1:0] right_of(input logic [IDX_W-1:0] p);
    return (IDX_W+2)'({1'b0, p, 1'b1} + 1'b1);
  endfunction

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .rdata0 (ram_rdata0),
    .raddr1 (ram_raddr1),
    .rdata1 (ram_rdata1)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sift-up / sift-down compare terms for the current hole position
  assign par_idx    = parent_of(pos_r);
  assign left_idx   = left_of(pos_r);
  assign right_idx  = right_of(pos_r);
  assign left_ok    = left_idx  < (IDX_W+2)'(count_r);
  assign right_ok   = right_idx < (IDX_W+2)'(count_r);
  assign left_key   = $signed(ram_rdata0);
  assign right_key  = $signed(ram_rdata1);
  assign take_left  = left_ok && (left_key < key_r);
  assign best_key   = take_left ? left_key : key_r;
  assign take_right = right_ok && (right_key < best_key);

  // Sequencer next state, RAM control and result staging
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    res_key_nxt   = res_key_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = key_r;
    ram_raddr0    = '0;
    ram_raddr1    = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_key_nxt  = '0;
          res_stat_nxt = ST_OK;
          if (in_data.opcode == OP_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              res_stat_nxt = ST_FULL;
              state_nxt    = S_DONE;
            end else begin
              count_nxt = count_r + 1'b1;
              key_nxt   = in_data.key_in;
              if (count_r == '0) begin
                // first key goes straight to the root
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_data.key_in;
                state_nxt = S_DONE;
              end else begin
                pos_nxt    = count_r[IDX_W-1:0];
                ram_raddr0 = parent_of(count_r[IDX_W-1:0]);
                state_nxt  = S_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              res_stat_nxt = ST_EMPTY;
              state_nxt    = S_DONE;
            end else begin
              // fetch root and last entry together
              count_nxt  = count_r - 1'b1;
              ram_raddr0 = '0;
              ram_raddr1 = IDX_W'(count_r - 1'b1);
              state_nxt  = S_ROOT;
            end
          end
        end
      end

      S_ROOT: begin
        res_key_nxt = $signed(ram_rdata0);
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          key_nxt    = $signed(ram_rdata1);
          pos_nxt    = '0;
          ram_raddr0 = IDX_W'(left_of('0));
          ram_raddr1 = IDX_W'(right_of('0));
          state_nxt  = S_DOWN;
        end
      end

      S_UP: begin
        if (key_r < $signed(ram_rdata0)) begin
          // parent moves down into the hole
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = ram_rdata0;
          pos_nxt   = par_idx;
          if (par_idx == '0) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr0 = parent_of(par_idx);
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = key_r;
          state_nxt = S_DONE;
        end
      end

      S_DOWN: begin
        if (take_right) begin
          ram_we     = 1'b1;
          ram_waddr  = pos_r;
          ram_wdata  = right_key;
          pos_nxt    = right_idx[IDX_W-1:0];
          ram_raddr0 = IDX_W'(left_of(right_idx[IDX_W-1:0]));
          ram_raddr1 = IDX_W'(right_of(right_idx[IDX_W-1:0]));
        end else if (take_left) begin
          ram_we     = 1'b1;
          ram_waddr  = pos_r;
          ram_wdata  = left_key;
          pos_nxt    = left_idx[IDX_W-1:0];
          ram_raddr0 = IDX_W'(left_of(left_idx[IDX_W-1:0]));
          ram_raddr1 = IDX_W'(right_of(left_idx[IDX_W-1:0]));
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = key_r;
          state_nxt = S_DONE;
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = key_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.key_out     = res_key_r;
          out_data_nxt.status      = res_stat_r;
          out_data_nxt.count_after = count_r;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    res_key_r  <= res_key_nxt;
    res_stat_r <= res_stat_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("heap count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.count_after == CNT_W'(CAPACITY))
    else $error("full refusal with wrong count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.count_after == '0 && out_data.key_out == '0)
    else $error("empty refusal with wrong fields");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && state_r == S_IDLE |-> in_xfer && count_r == '0)
    else $error("heap RAM written while idle without an insert");

endmodule

`default_nettype wire
